// ----- rtl/core/ncel_pkg.sv -----
// ----------------------------------------------------------------------------
// ncel_pkg
// Shared types and constants of the nearest-color elevation lookup: table
// geometry, field widths, controller states and the controller/datapath bus.
// ----------------------------------------------------------------------------
`default_nettype none

package ncel_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ELEV_W      = 16;
  localparam int COLOR_W     = 8;
  localparam int COUNT_W     = 9;
  localparam int DIST_W      = 18;
  localparam int GRAY_W      = 8;
  localparam int DIV_STEPS   = GRAY_W + 1;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int NUM_W       = ELEV_W + GRAY_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 32;

  localparam logic signed [ELEV_W-1:0] RESET_MIN_ELEV = -16'sd9150;
  localparam logic signed [ELEV_W-1:0] RESET_MAX_ELEV = 16'sd10760;
  localparam logic [GRAY_W-1:0]        GRAY_FULL      = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ELEV    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELEV    = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } ncel_state_t;

  typedef struct packed {
    logic mem_write;
    logic scan_start;
    logic scan_run;
    logic div_start;
    logic div_step;
    logic out_load;
  } ncel_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_last;
    logic out_free;
  } ncel_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/ncel_ctrl.sv -----
// ----------------------------------------------------------------------------
// ncel_ctrl
// Sequencer: accept a beat, run the table scan, the gray scaling steps and
// the hand-off into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncel_ctrl
  import ncel_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_opcode,
  output logic              in_ready,
  input  wire ncel_status_t status,
  output ncel_cmd_t         cmd
);

  ncel_state_t state;
  ncel_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (in_opcode == OP_LOOKUP)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.mem_write  = in_valid && (in_opcode == OP_WRITE);
        cmd.scan_start = in_valid && (in_opcode == OP_LOOKUP);
      end
      ST_SCAN: cmd.scan_run  = 1'b1;
      ST_PREP: cmd.div_start = 1'b1;
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_DONE: cmd.out_load  = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/ncel_dp.sv -----
// ----------------------------------------------------------------------------
// ncel_dp
// Datapath: configuration registers, color/elevation table memory, distance
// pipeline with best-match tracking, gray divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncel_dp
  import ncel_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire ncel_cmd_t             cmd,
  output ncel_status_t               status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic                       out_empty
);

  localparam int ROW_W = 3 * COLOR_W + ELEV_W;

  // input beat fields
  logic [IDX_W-1:0]          in_idx;
  logic [COLOR_W-1:0]        in_r, in_g, in_b;
  logic signed [ELEV_W-1:0]  in_elev;

  assign in_idx  = in_data[7:0];
  assign in_r    = in_data[15:8];
  assign in_g    = in_data[23:16];
  assign in_b    = in_data[31:24];
  assign in_elev = in_data[47:32];

  // configuration
  logic [COUNT_W-1:0]        table_count;
  logic signed [ELEV_W-1:0]  min_elev;
  logic signed [ELEV_W-1:0]  max_elev;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
      min_elev    <= RESET_MIN_ELEV;
      max_elev    <= RESET_MAX_ELEV;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_COUNT: table_count <= cfg_data[COUNT_W-1:0];
        REG_MIN_ELEV:    min_elev    <= cfg_data[ELEV_W-1:0];
        REG_MAX_ELEV:    max_elev    <= cfg_data[ELEV_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the count to the table depth
  logic [CNT_W-1:0] scan_len;
  always_comb begin
    if (COUNT_W'(table_count) > COUNT_W'(TABLE_DEPTH)) begin
      scan_len = CNT_W'(TABLE_DEPTH);
    end else begin
      scan_len = CNT_W'(table_count);
    end
  end

  // table memory: {elev, b, g, r}
  logic [ROW_W-1:0] mem [TABLE_DEPTH];
  logic [ROW_W-1:0] rd_row;

  logic [CNT_W-1:0] addr;
  logic             issue;

  assign issue = cmd.scan_run && (addr < scan_len);

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[in_idx] <= {in_elev, in_b, in_g, in_r};
    end
    rd_row <= mem[addr[IDX_W-1:0]];
  end

  // pixel and scan address
  logic [COLOR_W-1:0] px_r, px_g, px_b;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      px_r <= in_r;
      px_g <= in_g;
      px_b <= in_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      addr <= '0;
    end else if (issue) begin
      addr <= addr + 1'b1;
    end
  end

  // stage 1: read data valid
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
    rd_idx <= addr[IDX_W-1:0];
  end

  // stage 2: per-channel squares
  logic signed [COLOR_W:0]     dr, dg, db;
  logic signed [2*COLOR_W+1:0] pr, pg, pb;

  assign dr = $signed({1'b0, px_r}) - $signed({1'b0, rd_row[7:0]});
  assign dg = $signed({1'b0, px_g}) - $signed({1'b0, rd_row[15:8]});
  assign db = $signed({1'b0, px_b}) - $signed({1'b0, rd_row[23:16]});
  assign pr = dr * dr;
  assign pg = dg * dg;
  assign pb = db * db;

  logic                     sq_valid;
  logic [2*COLOR_W-1:0]     sq_r, sq_g, sq_b;
  logic [IDX_W-1:0]         sq_idx;
  logic signed [ELEV_W-1:0] sq_elev;

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= rd_valid;
    end
    sq_r    <= pr[2*COLOR_W-1:0];
    sq_g    <= pg[2*COLOR_W-1:0];
    sq_b    <= pb[2*COLOR_W-1:0];
    sq_idx  <= rd_idx;
    sq_elev <= rd_row[ROW_W-1:3*COLOR_W];
  end

  // stage 3: sum and keep the first strict minimum
  logic [DIST_W-1:0]        cur_dist;
  logic                     found;
  logic [DIST_W-1:0]        best_d;
  logic [IDX_W-1:0]         best_i;
  logic signed [ELEV_W-1:0] best_h;

  assign cur_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_start) begin
      found  <= 1'b0;
      best_i <= '0;
    end else if (sq_valid && (!found || (cur_dist < best_d))) begin
      found  <= 1'b1;
      best_i <= sq_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_valid && (!found || (cur_dist < best_d))) begin
      best_d <= cur_dist;
      best_h <= sq_elev;
    end
  end

  assign status.scan_done = (addr >= scan_len) && !rd_valid && !sq_valid;

  // gray scaling: (elev - min) * 255 / (max - min); a saturation check, then one quotient bit a step
  logic signed [ELEV_W-1:0] elev_sel;
  logic signed [ELEV_W:0]   diff;
  logic signed [ELEV_W:0]   span;
  logic signed [NUM_W:0]    num;

  assign elev_sel = found ? best_h : '1;
  assign diff     = $signed({elev_sel[ELEV_W-1], elev_sel}) -
                    $signed({min_elev[ELEV_W-1], min_elev});
  assign span     = $signed({max_elev[ELEV_W-1], max_elev}) -
                    $signed({min_elev[ELEV_W-1], min_elev});
  assign num      = $signed({diff, {GRAY_W{1'b0}}}) -
                    $signed({{GRAY_W{diff[ELEV_W]}}, diff});

  logic signed [ELEV_W-1:0] res_elev;
  logic                     res_empty;
  logic [IDX_W-1:0]         res_idx;
  logic [NUM_W-1:0]         rem;
  logic [ELEV_W-1:0]        divisor;
  logic                     gray_zero;
  logic                     gray_sat;
  logic [GRAY_W-1:0]        quot;
  logic [STEP_W-1:0]        step;

  logic [STEP_W-1:0]        shamt;
  logic [NUM_W:0]           shifted;
  logic                     fits;

  assign shamt   = (step == '0) ? STEP_W'(GRAY_W) : STEP_W'(GRAY_W) - step;
  assign shifted = (NUM_W+1)'(divisor) << shamt;
  assign fits    = {1'b0, rem} >= shifted;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      res_elev  <= elev_sel;
      res_empty <= !found;
      res_idx   <= found ? best_i : '0;
      rem       <= num[NUM_W-1:0];
      divisor   <= span[ELEV_W-1:0];
      gray_zero <= span[ELEV_W] || (span == '0) || num[NUM_W];
      gray_sat  <= 1'b0;
      quot      <= '0;
      step      <= '0;
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
      if (step == '0) begin
        gray_sat <= fits;
      end else begin
        quot <= {quot[GRAY_W-2:0], fits};
        if (fits) begin
          rem <= rem - shifted[NUM_W-1:0];
        end
      end
    end
  end

  assign status.div_last = (step == STEP_W'(DIV_STEPS - 1));

  // output register
  logic [GRAY_W-1:0] gray;
  assign gray = gray_zero ? '0 : (gray_sat ? GRAY_FULL : quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data  <= {res_idx, gray, res_elev};
      out_empty <= res_empty;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- rtl/core/nearest_color_elevation_lookup.sv -----
// ----------------------------------------------------------------------------
// nearest_color_elevation_lookup
// Color relief table lookup: find the table color nearest to a pixel and
// return its elevation, index and a gray level scaled between two elevations.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                    handshake
//  s_axis    in   tdata: entry_index, red, green, blue,      tvalid/tready
//                 entry_elevation; tuser: opcode
//  m_axis    out  tdata: elevation, gray_level, match_index  tvalid/tready
//                 tuser: table_empty
//  cfg       in   cfg_index, cfg_data                        cfg_we
//
//  A write beat leaves s_axis open. A lookup keeps s_axis closed while it
//  scans n entries, n = table_count capped at 256, one entry a cycle, then
//  drains the distance pipeline, sets up, runs nine divider steps and loads.
//  rst is synchronous: it clears the count and restores the span, not the table.
//  A result waits in the output register while the next beat is taken; a
//  lookup that finishes while that register is still full holds.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_color_elevation_lookup
  import ncel_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // entry_index[7:0], color_red[15:8], color_green[23:16],
  // color_blue[31:24], entry_elevation[47:32]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic                  s_axis_tuser,
  // result beats
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // elevation[15:0], gray_level[23:16], match_index[31:24]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // table_empty[0]
  output logic                       m_axis_tuser
);

  ncel_cmd_t    cmd;
  ncel_status_t status;

  // sequencer: accepts beats only when idle, steps the datapath
  ncel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_opcode (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // table, scan pipeline, divider and output register
  ncel_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_empty (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ncel_checker.sv -----
// ----------------------------------------------------------------------------
// ncel_checker
// Port-level checks of the nearest-color elevation lookup, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ncel_checker
  import ncel_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  // no stale result survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // an empty table reports elevation -1 and index 0
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[15:0] == 16'hFFFF) && (m_axis_tdata[31:24] == 8'd0))
    else $error("empty table result malformed");

  // a lookup beat closes s_axis in the cycle after it is taken
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOOKUP)) |=>
      !s_axis_tready)
    else $error("ready held through a lookup");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind nearest_color_elevation_lookup ncel_checker u_ncel_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
